[hw/rtl/sorted_priority_queue_top_defines.svh]
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Sizes, operation and status codes, and the control bundle sent to the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int VALUE_WIDTH = 16;
    localparam int PRIO_W      = 32;
    localparam int TAG_W       = 16;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_PEEK   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic                     insert;
        logic                     pop;
        logic signed [PRIO_W-1:0] prio;
        logic [VALUE_WIDTH-1:0]   value;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/spq_if.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue channels
// Valid/ready channels for request beats and response beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface spq_in_if import spq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               op;
    logic signed [PRIO_W-1:0] new_priority;
    logic [TAG_W-1:0]         new_value;

    modport source (output valid, output op, output new_priority, output new_value,
                    input ready);
    modport sink (input valid, input op, input new_priority, input new_value,
                  output ready);
endinterface

interface spq_out_if import spq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     head_valid;
    logic [TAG_W-1:0]         head_value;
    logic signed [PRIO_W-1:0] head_priority;
    logic [COUNT_W-1:0]       entry_total;
    logic [1:0]               status;

    modport source (output valid, output head_valid, output head_value,
                    output head_priority, output entry_total, output status,
                    input ready);
    modport sink (input valid, input head_valid, input head_value,
                  input head_priority, input entry_total, input status,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/spq_cell.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// One slot of the sorted chain: compares, then keeps, loads or shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell import spq_pkg::*; (
    input  wire logic                     clk,
    input  wire cell_ctrl_t               ctrl,
    input  wire logic                     occupied,
    input  wire logic                     left_take,
    input  wire logic signed [PRIO_W-1:0] left_prio,
    input  wire logic [VALUE_WIDTH-1:0]   left_value,
    input  wire logic signed [PRIO_W-1:0] right_prio,
    input  wire logic [VALUE_WIDTH-1:0]   right_value,
    output logic                          take,
    output logic signed [PRIO_W-1:0]      prio,
    output logic [VALUE_WIDTH-1:0]        value,
    output logic signed [PRIO_W-1:0]      prio_next,
    output logic [VALUE_WIDTH-1:0]        value_next
);

    logic signed [PRIO_W-1:0] prio_reg;
    logic [VALUE_WIDTH-1:0]   value_reg;

    // The chain is sorted, so take rises once and stays high toward the tail.
    assign take  = !occupied || (prio_reg <= ctrl.prio);
    assign prio  = prio_reg;
    assign value = value_reg;

    always_comb
    begin
        priority if (ctrl.insert && left_take)
        begin
            prio_next  = left_prio;
            value_next = left_value;
        end
        else if (ctrl.insert && take)
        begin
            prio_next  = ctrl.prio;
            value_next = ctrl.value;
        end
        else if (ctrl.pop)
        begin
            prio_next  = right_prio;
            value_next = right_value;
        end
        else
        begin
            prio_next  = prio_reg;
            value_next = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg  <= prio_next;
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

[hw/rtl/sorted_priority_queue_top.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue top level
// A chain of compare-and-shift cells holding entries highest priority first.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload
//  req      in   op, new_priority, new_value
//  rsp      out  head_valid, head_value, head_priority, entry_total, status
//
//  The cells compare in parallel and shift in the same edge, so a beat can be
//  taken in each cycle unless a held response stalls the request side.
//  The response is registered and appears in the cycle after the request beat.
//  A held response stalls the request side only while rsp.ready is low.
//  Reset empties the queue at once; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_priority_queue_top_defines.svh"

module sorted_priority_queue_top import spq_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    spq_in_if.sink    req,
    spq_out_if.source rsp
);

    logic [COUNT_W-1:0]       count_reg;
    logic [COUNT_W-1:0]       count_next;
    logic                     rsp_valid_reg;
    logic                     head_valid_reg;
    logic [TAG_W-1:0]         head_value_reg;
    logic signed [PRIO_W-1:0] head_priority_reg;
    logic [COUNT_W-1:0]       entry_total_reg;
    logic [1:0]               status_reg;

    logic       accept;
    logic       is_full;
    logic       is_empty;
    logic [1:0] status_next;
    cell_ctrl_t ctrl;

    logic                     take_w  [QUEUE_DEPTH];
    logic signed [PRIO_W-1:0] prio_w  [QUEUE_DEPTH];
    logic [VALUE_WIDTH-1:0]   value_w [QUEUE_DEPTH];
    logic signed [PRIO_W-1:0] prio_nx [QUEUE_DEPTH];
    logic [VALUE_WIDTH-1:0]   value_nx[QUEUE_DEPTH];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign is_full   = (count_reg == COUNT_W'(QUEUE_DEPTH));
    assign is_empty  = (count_reg == '0);

    always_comb
    begin
        ctrl.insert = accept && (req.op == OP_INSERT) && !is_full;
        ctrl.pop    = accept && (req.op == OP_POP) && !is_empty;
        ctrl.prio   = req.new_priority;
        ctrl.value  = VALUE_WIDTH'(req.new_value);
        priority if (req.op == OP_INSERT && is_full)
            status_next = STATUS_FULL;
        else if (req.op == OP_POP && is_empty)
            status_next = STATUS_EMPTY;
        else
            status_next = STATUS_OK;
        priority if (ctrl.insert)
            count_next = count_reg + COUNT_W'(1);
        else if (ctrl.pop)
            count_next = count_reg - COUNT_W'(1);
        else
            count_next = count_reg;
    end

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic                     left_take;
        logic signed [PRIO_W-1:0] left_prio;
        logic [VALUE_WIDTH-1:0]   left_value;
        logic signed [PRIO_W-1:0] right_prio;
        logic [VALUE_WIDTH-1:0]   right_value;

        if (i == 0)
        begin : g_head
            assign left_take  = 1'b0;
            assign left_prio  = ctrl.prio;
            assign left_value = ctrl.value;
        end
        else
        begin : g_body
            assign left_take  = take_w[i-1];
            assign left_prio  = prio_w[i-1];
            assign left_value = value_w[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_prio  = prio_w[i];
            assign right_value = value_w[i];
        end
        else
        begin : g_inner
            assign right_prio  = prio_w[i+1];
            assign right_value = value_w[i+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupied    (count_reg > COUNT_W'(i)),
            .left_take   (left_take),
            .left_prio   (left_prio),
            .left_value  (left_value),
            .right_prio  (right_prio),
            .right_value (right_value),
            .take        (take_w[i]),
            .prio        (prio_w[i]),
            .value       (value_w[i]),
            .prio_next   (prio_nx[i]),
            .value_next  (value_nx[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            head_valid_reg    <= (count_next != '0);
            head_value_reg    <= (count_next != '0) ? TAG_W'(value_nx[0]) : '0;
            head_priority_reg <= (count_next != '0) ? prio_nx[0] : '0;
            entry_total_reg   <= count_next;
            status_reg        <= status_next;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.head_valid    = head_valid_reg;
    assign rsp.head_value    = head_value_reg;
    assign rsp.head_priority = head_priority_reg;
    assign rsp.entry_total   = entry_total_reg;
    assign rsp.status        = status_reg;

    `SPQ_ASSERT_SAME(a_count_range, 1'b1, count_reg <= COUNT_W'(QUEUE_DEPTH),
                     "fill count overflow")
    `SPQ_ASSERT_NEXT(a_full_drop, accept && req.op == OP_INSERT && is_full,
                     status_reg == STATUS_FULL && $stable(count_reg),
                     "full insert not dropped")
    `SPQ_ASSERT_NEXT(a_rsp_count, accept,
                     rsp_valid_reg && entry_total_reg == count_reg,
                     "response count mismatch")
    `SPQ_ASSERT_SAME(a_head_valid, rsp_valid_reg,
                     head_valid_reg == (entry_total_reg != '0),
                     "head valid inconsistent")
    `SPQ_ASSERT_SAME(a_sorted_head, count_reg >= COUNT_W'(2), prio_w[0] >= prio_w[1],
                     "head not highest")

endmodule

`default_nettype wire

[bench/tb_sorted_priority_queue_top.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives request beats with random gaps, keeps a software copy of the sorted
// queue to predict the head report of every beat, and checks each response
// beat against it while the response side stalls at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sorted_priority_queue_top;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_BEATS = 1100;

    typedef struct packed {
        logic                     head_valid;
        logic [TAG_W-1:0]         head_value;
        logic signed [PRIO_W-1:0] head_priority;
        logic [COUNT_W-1:0]       entry_total;
        logic [1:0]               status;
    } head_report_t;

    class head_scoreboard;
        logic signed [PRIO_W-1:0] slot_prio [QUEUE_DEPTH];
        logic [VALUE_WIDTH-1:0]   slot_tag [QUEUE_DEPTH];
        int                       fill_level = 0;
        head_report_t             pending_heads [$];
        int                       mismatches = 0;

        function void note_request(input logic [1:0] op, input logic signed [PRIO_W-1:0] prio,
                                   input logic [TAG_W-1:0] value);
            head_report_t rpt;
            int           pos;
            rpt = '0;
            rpt.status = STATUS_OK;
            case (op)
                OP_INSERT:
                begin
                    if (fill_level >= QUEUE_DEPTH)
                    begin
                        rpt.status = STATUS_FULL;
                    end
                    else
                    begin
                        pos = fill_level;
                        for (int i = fill_level - 1; i >= 0; i--)
                        begin
                            if (slot_prio[i] <= prio)
                            begin
                                pos = i;
                            end
                        end
                        for (int i = fill_level; i > pos; i--)
                        begin
                            slot_prio[i] = slot_prio[i-1];
                            slot_tag[i]  = slot_tag[i-1];
                        end
                        slot_prio[pos] = prio;
                        slot_tag[pos]  = VALUE_WIDTH'(value);
                        fill_level++;
                    end
                end
                OP_POP:
                begin
                    if (fill_level == 0)
                    begin
                        rpt.status = STATUS_EMPTY;
                    end
                    else
                    begin
                        for (int i = 1; i < fill_level; i++)
                        begin
                            slot_prio[i-1] = slot_prio[i];
                            slot_tag[i-1]  = slot_tag[i];
                        end
                        fill_level--;
                    end
                end
                default:
                begin
                end
            endcase
            if (fill_level > 0)
            begin
                rpt.head_valid    = 1'b1;
                rpt.head_value    = TAG_W'(slot_tag[0]);
                rpt.head_priority = slot_prio[0];
            end
            rpt.entry_total = COUNT_W'(fill_level);
            pending_heads.push_back(rpt);
        endfunction

        function void check_response(input head_report_t got);
            head_report_t want;
            if (pending_heads.size() == 0)
            begin
                $display("%0t: unexpected response beat, got %p", $realtime, got);
                mismatches++;
                return;
            end
            want = pending_heads.pop_front();
            if (got.head_valid !== want.head_valid)
            begin
                $display("%0t: head_valid expected %0d got %0d", $realtime,
                         want.head_valid, got.head_valid);
                mismatches++;
            end
            if (got.head_value !== want.head_value)
            begin
                $display("%0t: head_value expected %h got %h", $realtime,
                         want.head_value, got.head_value);
                mismatches++;
            end
            if (got.head_priority !== want.head_priority)
            begin
                $display("%0t: head_priority expected %0d got %0d", $realtime,
                         want.head_priority, got.head_priority);
                mismatches++;
            end
            if (got.entry_total !== want.entry_total)
            begin
                $display("%0t: entry_total expected %0d got %0d", $realtime,
                         want.entry_total, got.entry_total);
                mismatches++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d got %0d", $realtime,
                         want.status, got.status);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_heads.size();
        endfunction

        function bit clean();
            return (mismatches == 0) && (pending_heads.size() == 0);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    spq_in_if  req_ch ();
    spq_out_if rsp_ch ();

    sorted_priority_queue_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    head_scoreboard sb;
    bit             quiet_sender;
    int             insert_pct;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 11) == 0)
        begin
            return $urandom_range(10, 40);
        end
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
    endfunction

    function automatic logic signed [PRIO_W-1:0] random_priority();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
        begin
            return PRIO_W'($signed($urandom_range(0, 8)) - 4);
        end
        if (pick == 4)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [1:0] random_op();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)
        begin
            return OP_UNUSED;
        end
        if (pick < 13)
        begin
            return OP_PEEK;
        end
        return ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_POP;
    endfunction

    task automatic send_request(input logic [1:0] op, input logic signed [PRIO_W-1:0] prio,
                                input logic [TAG_W-1:0] value);
        int gap;
        gap = quiet_sender ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.op           <= op;
        req_ch.new_priority <= prio;
        req_ch.new_value    <= value;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        sb.note_request(op, prio, value);
    endtask

    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (sb.outstanding() != 0);
    endtask

    initial
    begin
        int hold;
        int cycle;
        bit calm;
        hold  = 0;
        cycle = 0;
        calm  = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                sb.check_response('{rsp_ch.head_valid, rsp_ch.head_value,
                                    rsp_ch.head_priority, rsp_ch.entry_total,
                                    rsp_ch.status});
            end
            cycle++;
            if (cycle % 150 == 0)
            begin
                calm = ($urandom_range(0, 2) == 0);
            end
            if (hold > 0)
            begin
                hold--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                hold = pick_gap();
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        sb           = new();
        quiet_sender = 1'b0;
        insert_pct   = 50;
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.op           <= OP_PEEK;
        req_ch.new_priority <= '0;
        req_ch.new_value    <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty queue: peek, pop and the unused code.
        send_request(OP_PEEK, 32'sd0, 16'h0000);
        send_request(OP_POP, 32'sd0, 16'h0000);
        send_request(OP_UNUSED, 32'h7FFF_FFFF, 16'hFFFF);
        send_request(OP_INSERT, 32'h7FFF_FFFF, 16'hFFFF);
        send_request(OP_INSERT, 32'h8000_0000, 16'h0000);
        send_request(OP_INSERT, 32'sd0, 16'hA5A5);
        // An equal priority goes ahead of the stored one.
        send_request(OP_INSERT, 32'sd0, 16'h5A5A);
        send_request(OP_UNUSED, 32'sd0, 16'h0000);
        send_request(OP_POP, 32'sd0, 16'h0000);
        send_request(OP_POP, 32'sd0, 16'h0000);
        for (int i = 0; i < 14; i++)
        begin
            send_request(OP_INSERT, PRIO_W'((i % 5) * 1000 - 2000), TAG_W'(i + 1));
        end
        send_request(OP_INSERT, 32'h7FFF_FFFF, 16'h1234);
        drain_responses();

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n % 60 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: insert_pct = 80;
                    1: insert_pct = 50;
                    default: insert_pct = 20;
                endcase
                quiet_sender = ($urandom_range(0, 3) == 0);
            end
            if (n == RANDOM_BEATS / 2 || $urandom_range(0, 199) == 0)
            begin
                drain_responses();
            end
            send_request(random_op(), random_priority(), TAG_W'($urandom));
        end

        drain_responses();
        repeat (10) @(posedge clk);
        if (sb.clean())
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
+incdir+hw/rtl
hw/rtl/spq_pkg.sv
hw/rtl/spq_if.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue_top.sv
bench/tb_sorted_priority_queue_top.sv
